// ----- hdl/hkrb_pkg.sv -----
//------------------------------------------------------------------------------
// hkrb_pkg: shared types and constants for the keyboard report builder
// Event kinds, controller states and the command/status bundles that join
// the controller to the datapath.
//------------------------------------------------------------------------------
`default_nettype none

package hkrb_pkg;

    // Default number of key table slots.
    localparam int KEY_SLOTS_DEF = 6;
    // Number of key bytes that a report carries.
    localparam int REPORT_SLOTS  = 6;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 64;

    // Modifier usage range.
    localparam logic [7:0] MOD_FIRST = 8'hE0;
    localparam logic [7:0] MOD_LAST  = 8'hE7;

    // Reset value of the report identifier register.
    localparam logic [7:0] REPORT_ID_RST = 8'd1;

    typedef enum logic [1:0] {
        KIND_KEY     = 2'd0,
        KIND_KEY_MOD = 2'd1,
        KIND_TAP     = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT_PRE,
        S_REL,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;       // capture the incoming event
        logic tbl_en;     // write the key table
        logic tbl_press;  // 1 insert, 0 remove
        logic mod_en;     // write the modifier byte
        logic emit;       // load the output register
        logic emit_last;  // tlast of the report being loaded
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  pressed;
        logic  mod_hit;    // selected usage is a modifier
        logic  press_chg;  // insertion would change the table
        logic  rel_chg;    // removal counts as a change
        logic  mod_chg;    // modifier update would change the byte
        logic  out_free;   // output register can take a report
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- hdl/hkrb_ctrl.sv -----
//------------------------------------------------------------------------------
// hkrb_ctrl: event sequencing state machine
// Steps each event through its update and, on a change, a final report; a tap
// runs update, optional press report, release update and final report.
//------------------------------------------------------------------------------
`default_nettype none

module hkrb_ctrl
    import hkrb_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.kind)
                    KIND_KEY: begin
                        if (i_stat.mod_hit ? i_stat.mod_chg
                                : (i_stat.pressed ? i_stat.press_chg : i_stat.rel_chg)) begin
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    KIND_KEY_MOD: begin
                        if ((i_stat.pressed ? i_stat.press_chg : i_stat.rel_chg)
                                || i_stat.mod_chg) begin
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    KIND_TAP: begin
                        n_state = i_stat.press_chg ? S_EMIT_PRE : S_REL;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_EMIT_PRE: begin
                if (i_stat.out_free) begin
                    n_state = S_REL;
                end
            end
            S_REL: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // No event is taken while reset is held.
                o_in_ready = i_rst_n;
                o_cmd.load = i_in_valid && i_rst_n;
            end
            S_EXEC: begin
                unique case (i_stat.kind)
                    KIND_KEY: begin
                        o_cmd.mod_en    = i_stat.mod_hit;
                        o_cmd.tbl_en    = !i_stat.mod_hit;
                        o_cmd.tbl_press = i_stat.pressed;
                    end
                    KIND_KEY_MOD: begin
                        o_cmd.mod_en    = 1'b1;
                        o_cmd.tbl_en    = 1'b1;
                        o_cmd.tbl_press = i_stat.pressed;
                    end
                    KIND_TAP: begin
                        o_cmd.tbl_en    = 1'b1;
                        o_cmd.tbl_press = 1'b1;
                    end
                    default: begin
                        o_cmd.tbl_en = 1'b0;
                    end
                endcase
            end
            S_EMIT_PRE: begin
                o_cmd.emit      = i_stat.out_free;
                o_cmd.emit_last = 1'b0;
            end
            S_REL: begin
                o_cmd.tbl_en    = 1'b1;
                o_cmd.tbl_press = 1'b0;
            end
            S_EMIT: begin
                o_cmd.emit      = i_stat.out_free;
                o_cmd.emit_last = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/hkrb_datapath.sv -----
//------------------------------------------------------------------------------
// hkrb_datapath: key table, modifier byte and report register
// Holds the event being worked on, computes insertion, removal and modifier
// updates, and keeps the outgoing report.
//------------------------------------------------------------------------------
`default_nettype none

module hkrb_datapath
    import hkrb_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [IN_DATA_W-1:0]  i_in_data,
    input  wire logic [IN_USER_W-1:0]  i_in_user,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [7:0]            i_cfg_wr_data,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [OUT_DATA_W-1:0]      o_out_data,
    output logic                       o_out_last
);

    logic [KEY_SLOTS-1:0][7:0] r_table;
    logic [KEY_SLOTS-1:0][7:0] n_press;
    logic [KEY_SLOTS-1:0][7:0] n_rel;
    logic [KEY_SLOTS-1:0][7:0] w_shift;
    logic [7:0]                r_mods;
    logic [7:0]                n_mods;
    logic [7:0]                r_rid;
    t_kind                     r_kind;
    logic [7:0]                r_code;
    logic [7:0]                r_mkey;
    logic                      r_press;
    logic                      r_out_valid;
    logic [OUT_DATA_W-1:0]     r_out_data;
    logic                      r_out_last;
    logic [7:0]                w_usage;
    logic [7:0]                w_mask;
    logic                      w_press_chg;
    logic                      w_rel_chg;
    logic [REPORT_SLOTS*8-1:0] w_slots;

    // Insertion: the first slot that holds the code or is empty decides.
    always_comb begin
        logic seen;
        logic hit;
        seen        = 1'b0;
        w_press_chg = 1'b0;
        for (int j = 0; j < KEY_SLOTS; j++) begin
            hit = (r_table[j] == r_code) || (r_table[j] == 8'd0);
            if (hit && !seen && (r_table[j] != r_code)) begin
                n_press[j]  = r_code;
                w_press_chg = 1'b1;
            end else begin
                n_press[j] = r_table[j];
            end
            seen = seen | hit;
        end
    end

    // Removal: from the first matching slot on, later slots move down one.
    assign w_shift = r_table >> 8;

    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int j = 0; j < KEY_SLOTS; j++) begin
            seen     = seen | (r_table[j] == r_code);
            n_rel[j] = seen ? w_shift[j] : r_table[j];
        end
        w_rel_chg = seen;
    end

    // Modifier usage comes from the key code for plain key events.
    assign w_usage = (r_kind == KIND_KEY_MOD) ? r_mkey : r_code;
    assign w_mask  = ((w_usage >= MOD_FIRST) && (w_usage <= MOD_LAST))
                   ? (8'd1 << w_usage[2:0]) : 8'd0;
    assign n_mods  = r_press ? (r_mods | w_mask) : (r_mods & ~w_mask);

    always_comb begin
        w_slots = '0;
        for (int i = 0; i < REPORT_SLOTS; i++) begin
            if (i < KEY_SLOTS) begin
                w_slots[i*8 +: 8] = r_table[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table     <= '0;
            r_mods      <= 8'd0;
            r_rid       <= REPORT_ID_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_rid <= i_cfg_wr_data;
            end
            if (i_cmd.tbl_en) begin
                r_table <= i_cmd.tbl_press ? n_press : n_rel;
            end
            if (i_cmd.mod_en) begin
                r_mods <= n_mods;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= t_kind'(i_in_user);
            r_code  <= i_in_data[7:0];
            r_mkey  <= i_in_data[15:8];
            r_press <= i_in_data[16];
        end
        if (i_cmd.emit) begin
            r_out_data <= {w_slots, r_mods, r_rid};
            r_out_last <= i_cmd.emit_last;
        end
    end

    assign o_stat.kind      = r_kind;
    assign o_stat.pressed   = r_press;
    assign o_stat.mod_hit   = (w_mask != 8'd0);
    assign o_stat.press_chg = w_press_chg;
    assign o_stat.rel_chg   = w_rel_chg;
    assign o_stat.mod_chg   = (n_mods != r_mods);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

// ----- hdl/hid_keyboard_report_builder_top.sv -----
//------------------------------------------------------------------------------
// hid_keyboard_report_builder_top: boot keyboard report builder
// Turns key press, release and tap events into keyboard reports that carry
// a report identifier, the modifier byte and up to six pressed key codes.
//------------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         key events: kind in tuser, key code, modifier, press
//  m_axis    out        keyboard reports, tlast on the final one per event
//  cfg       in         report identifier write
//
// A reporting key event steps through capture, table and modifier update, and
// report load. A tap that changes the table updates the table twice and loads
// two reports; other taps load only the final report.
// s_axis_tready is high only while the controller in hkrb_ctrl is idle and out
// of reset, so a report waiting in the output register stalls the next one.
// Reset is synchronous, active low: empty key table, modifiers zero, ident one.
//------------------------------------------------------------------------------
`default_nettype none

module hid_keyboard_report_builder_top
    import hkrb_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Event input.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [7:0] key_code, [15:8] mod_key, [16] pressed, [23:17] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] kind
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
    // Report output.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [7:0] kbd_rid, [15:8] modifiers, [63:16] key_slots
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast,
    // Report identifier register.
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [7:0]            i_cfg_wr_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // The controller sequences each transaction; the datapath holds the event, key table, modifiers and report.
    hkrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    hkrb_datapath #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_data     (s_axis_tdata),
        .i_in_user     (s_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_data    (m_axis_tdata),
        .o_out_last    (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // A report is only loaded when the output register can take it.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("report loaded over an untaken report");

    // While taking a new event the controller issues no update or report.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!w_cmd.tbl_en && !w_cmd.mod_en && !w_cmd.emit))
        else $error("work issued while accepting an event");

    // Taps never touch the modifier byte.
    a_tap_no_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mod_en |-> (w_stat.kind != KIND_TAP))
        else $error("modifier update during a tap");

    // A report is loaded only in the cycle after the controller left idle
    // or later, never together with capturing an event.
    a_no_load_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> !w_cmd.emit)
        else $error("event captured while loading a report");
`endif

endmodule

`default_nettype wire

// ----- dv/hid_keyboard_report_builder_top_tb.sv -----
//------------------------------------------------------------------------------
// hid_keyboard_report_builder_top_tb: self-checking bench for the report builder
// Drives key, modifier and tap events into the event stream and keeps its own
// copy of the key table, the modifier byte and the report identifier. Every
// report that leaves the block is compared field by field with the oldest
// predicted report. A short scripted sequence comes first, then random
// traffic in several phases, each with its own report identifier.
//------------------------------------------------------------------------------
module hid_keyboard_report_builder_top_tb
    import hkrb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int SLOTS          = KEY_SLOTS_DEF;
    localparam int PHASES         = 5;
    localparam int PHASE_EVENTS   = 220;
    // Idle time after the last report, long enough for the block to finish
    // an event that makes no report.
    localparam int SETTLE_CYCLES  = 10;
    localparam int TAIL_CYCLES    = 20;
    // Long stall of the report sink, long enough to back the block up.
    localparam int SINK_HOLD      = 400;
    // Cycles without any transaction before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;

    // One keyboard report as the block emits it.
    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  mods;
        logic [47:0] slots;
        logic        last;
    } t_report;

    // One key event. A typed_n of -1 means the expected reports come from the
    // predictor; 0 means no report is expected; 1 means the row carries its expected report.
    typedef struct {
        t_kind       kind;
        logic [7:0]  code;
        logic [7:0]  mkey;
        logic        prs;
        int          typed_n;
        logic [7:0]  mods;
        logic [47:0] slots;
    } t_key_event;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [7:0] key_code, [15:8] mod_key, [16] pressed, [23:17] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // [1:0] kind
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [7:0] kbd_rid, [15:8] modifiers, [63:16] key_slots
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_wr_en;
    logic [7:0]            i_cfg_wr_data;

    // Predicted state of the block.
    logic [7:0] key_table [SLOTS];
    logic [7:0] mod_byte;
    logic [7:0] kbd_rid_reg;

    t_report    fresh_reports[$];
    t_report    expected_reports[$];

    int         err_count    = 0;
    int         stall_cycles = 0;
    bit         feed_burst   = 1'b0;
    bit         sink_burst   = 1'b0;
    bit         sink_hold    = 1'b0;

    // Scripted events. The first rows run right after reset with identifier
    // one and build a full table step by step, so their reports are typed in.
    t_key_event directed_events [24] = '{
        '{KIND_KEY,     8'h04, 8'h00, 1'b1,  1, 8'h00, 48'h000000000004},
        '{KIND_KEY,     8'h04, 8'h00, 1'b1,  0, 8'h00, 48'h0},
        '{KIND_KEY,     8'h00, 8'h00, 1'b1,  0, 8'h00, 48'h0},
        '{KIND_KEY,     8'h00, 8'h00, 1'b0,  1, 8'h00, 48'h000000000004},
        '{KIND_KEY,     8'hE0, 8'h00, 1'b1,  1, 8'h01, 48'h000000000004},
        '{KIND_KEY,     8'hE7, 8'h00, 1'b1,  1, 8'h81, 48'h000000000004},
        '{KIND_KEY_MOD, 8'h05, 8'hE1, 1'b1,  1, 8'h83, 48'h000000000504},
        '{KIND_KEY_MOD, 8'hE2, 8'h10, 1'b1,  1, 8'h83, 48'h000000E20504},
        '{KIND_KEY,     8'h06, 8'hFF, 1'b1, -1, 8'h00, 48'h0},
        '{KIND_KEY,     8'h07, 8'h00, 1'b1, -1, 8'h00, 48'h0},
        '{KIND_KEY,     8'hFF, 8'h00, 1'b1,  1, 8'h83, 48'hFF0706E20504},
        '{KIND_KEY,     8'h08, 8'h00, 1'b1,  0, 8'h00, 48'h0},
        '{KIND_KEY,     8'h00, 8'h00, 1'b0,  0, 8'h00, 48'h0},
        '{KIND_KEY,     8'h09, 8'h00, 1'b0,  0, 8'h00, 48'h0},
        '{KIND_KEY,     8'h05, 8'h00, 1'b0,  1, 8'h83, 48'h00FF0706E204},
        '{KIND_TAP,     8'h11, 8'h00, 1'b0, -1, 8'h00, 48'h0},
        '{KIND_TAP,     8'h04, 8'h00, 1'b1, -1, 8'h00, 48'h0},
        '{KIND_NONE,    8'h3A, 8'hC5, 1'b1,  0, 8'h00, 48'h0},
        '{KIND_KEY_MOD, 8'hFF, 8'hE0, 1'b0, -1, 8'h00, 48'h0},
        '{KIND_KEY,     8'hE7, 8'h00, 1'b0, -1, 8'h00, 48'h0},
        '{KIND_KEY_MOD, 8'h00, 8'h00, 1'b1, -1, 8'h00, 48'h0},
        '{KIND_TAP,     8'h00, 8'hFF, 1'b1, -1, 8'h00, 48'h0},
        '{KIND_KEY_MOD, 8'h55, 8'hAA, 1'b0, -1, 8'h00, 48'h0},
        '{KIND_KEY,     8'hE5, 8'h00, 1'b0, -1, 8'h00, 48'h0}
    };

    hid_keyboard_report_builder_top #(
        .KEY_SLOTS(SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Report predictor
    // ---------------------------------------------------------------------

    // Bit of the modifier byte that a usage code selects, or zero when the
    // code lies outside the modifier range.
    function automatic logic [7:0] modifier_mask(logic [7:0] usage);
        if (usage < MOD_FIRST || usage > MOD_LAST) begin
            return 8'h00;
        end
        return 8'h01 << (usage - MOD_FIRST);
    endfunction

    // Insert or remove a code in the compacted key table. A press stops at
    // the first slot that already holds the code or is empty, so pressing
    // code zero never changes anything. A release closes the gap it leaves.
    function automatic bit edit_keys(logic [7:0] code, bit press);
        for (int i = 0; i < SLOTS; i++) begin
            if (press) begin
                if (key_table[i] == code) begin
                    return 1'b0;
                end
                if (key_table[i] == 8'h00) begin
                    key_table[i] = code;
                    return 1'b1;
                end
            end else if (key_table[i] == code) begin
                for (int j = i; j < SLOTS - 1; j++) begin
                    key_table[j] = key_table[j + 1];
                end
                key_table[SLOTS - 1] = 8'h00;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit edit_mods(logic [7:0] mask, bit press);
        logic [7:0] prev;
        prev     = mod_byte;
        mod_byte = press ? (mod_byte | mask) : (mod_byte & ~mask);
        return mod_byte != prev;
    endfunction

    function automatic void queue_report(bit last);
        t_report r;
        r.id    = kbd_rid_reg;
        r.mods  = mod_byte;
        r.slots = '0;
        for (int i = 0; i < SLOTS && i < REPORT_SLOTS; i++) begin
            r.slots[8*i +: 8] = key_table[i];
        end
        r.last  = last;
        fresh_reports.push_back(r);
    endfunction

    // Applies one event to the predicted state and leaves the reports that it
    // causes in fresh_reports.
    function automatic void model_event(t_kind kind, logic [7:0] code,
                                        logic [7:0] mkey, bit press);
        logic [7:0] mask;
        bit         keys_chg;
        bit         mods_chg;
        fresh_reports.delete();
        case (kind)
            KIND_KEY: begin
                // A modifier usage only touches the modifier byte here.
                mask = modifier_mask(code);
                if (mask != 8'h00) begin
                    keys_chg = edit_mods(mask, press);
                end else begin
                    keys_chg = edit_keys(code, press);
                end
                if (keys_chg) begin
                    queue_report(1'b1);
                end
            end
            KIND_KEY_MOD: begin
                // Both updates take place, whatever the first one returns.
                keys_chg = edit_keys(code, press);
                mods_chg = edit_mods(modifier_mask(mkey), press);
                if (keys_chg || mods_chg) begin
                    queue_report(1'b1);
                end
            end
            KIND_TAP: begin
                if (edit_keys(code, 1'b1)) begin
                    queue_report(1'b0);
                end
                void'(edit_keys(code, 1'b0));
                queue_report(1'b1);
            end
            default: begin
            end
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Event source
    // ---------------------------------------------------------------------

    // Offers one event after a random gap and waits for its transaction. The
    // predictor runs at the accepting edge. Entered and left at a falling
    // edge; tvalid stays high when the next gap is zero.
    task automatic send_event(input t_key_event ev);
        int gap;
        if ($urandom_range(0, 29) == 0) begin
            feed_burst = !feed_burst;
        end
        gap = feed_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, ev.prs, ev.mkey, ev.code};
        s_axis_tuser  <= ev.kind;
        do @(posedge i_clk); while (!s_axis_tready);
        model_event(ev.kind, ev.code, ev.mkey, ev.prs);
        if (ev.typed_n < 0) begin
            foreach (fresh_reports[i]) begin
                expected_reports.push_back(fresh_reports[i]);
            end
        end else if (ev.typed_n > 0) begin
            expected_reports.push_back({kbd_rid_reg, ev.mods, ev.slots, 1'b1});
        end
        @(negedge i_clk);
    endtask

    // Stops offering events until every predicted report has come out, then
    // gives the block time to finish an event that makes no report.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Report sink: random back-pressure, bursts without stalls, and one long
    // hold-off on request that lets the block fill up and stall its input.
    // ---------------------------------------------------------------------
    initial begin : report_sink
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (sink_hold) begin
                sink_hold = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (SINK_HOLD) @(negedge i_clk);
            end
            if ($urandom_range(0, 29) == 0) begin
                sink_burst = !sink_burst;
            end
            gap = sink_burst ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // ---------------------------------------------------------------------
    // Report checker
    // ---------------------------------------------------------------------
    task automatic log_mismatch(string what, logic [63:0] got, logic [63:0] want);
        err_count++;
        $display("[%0t] report mismatch on %s: got %h, expected %h",
                 $time, what, got, want);
    endtask

    // Every report transaction is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_reports.size() == 0) begin
                log_mismatch("unexpected report", m_axis_tdata, 64'd0);
            end else begin
                want = expected_reports.pop_front();
                if (m_axis_tdata[7:0] !== want.id) begin
                    log_mismatch("kbd_rid", 64'(m_axis_tdata[7:0]), 64'(want.id));
                end
                if (m_axis_tdata[15:8] !== want.mods) begin
                    log_mismatch("modifiers", 64'(m_axis_tdata[15:8]), 64'(want.mods));
                end
                if (m_axis_tdata[63:16] !== want.slots) begin
                    log_mismatch("key_slots", 64'(m_axis_tdata[63:16]), 64'(want.slots));
                end
                if (m_axis_tlast !== want.last) begin
                    log_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
                end
            end
        end
    end

    // The run is hung if no transaction happens on either side for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL hid_keyboard_report_builder_top");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin : main_seq
        t_key_event ev;
        int         count;
        int         u;
        logic [7:0] id_val;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 8'h00;
        foreach (key_table[i]) begin
            key_table[i] = 8'h00;
        end
        mod_byte      = 8'h00;
        kbd_rid_reg   = REPORT_ID_RST;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Scripted corner cases with the reset identifier.
        foreach (directed_events[i]) begin
            send_event(directed_events[i]);
        end

        // Random phases. Each phase after the first writes a new report
        // identifier while the block is idle: zero, all ones, then random.
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                settle();
                case (ph)
                    1:       id_val = 8'h00;
                    2:       id_val = 8'hFF;
                    default: id_val = 8'($urandom_range(0, 255));
                endcase
                i_cfg_wr_en   <= 1'b1;
                i_cfg_wr_data <= id_val;
                @(negedge i_clk);
                i_cfg_wr_en   <= 1'b0;
                kbd_rid_reg = id_val;
            end
            // The sink holds off at the start of this phase while events keep
            // coming, so the output register fills and the input stalls.
            if (ph == 2) begin
                sink_hold = 1'b1;
            end
            count = 0;
            while (count < PHASE_EVENTS) begin
                // Midway through one phase the source waits for every report.
                if (ph == 3 && count == PHASE_EVENTS / 2) begin
                    settle();
                end
                u = $urandom_range(0, 99);
                if (u < 45) begin
                    ev.kind = KIND_KEY;
                end else if (u < 75) begin
                    ev.kind = KIND_KEY_MOD;
                end else if (u < 95) begin
                    ev.kind = KIND_TAP;
                end else begin
                    ev.kind = KIND_NONE;
                end
                // Mostly a small pool of keys so the table fills and drains,
                // with modifier usages mixed in and some fully random codes.
                if ($urandom_range(0, 9) < 7) begin
                    if ($urandom_range(0, 3) == 0) begin
                        ev.code = 8'(MOD_FIRST + $urandom_range(0, 7));
                    end else begin
                        ev.code = 8'(8'h04 + $urandom_range(0, 8));
                    end
                end else begin
                    ev.code = 8'($urandom_range(0, 255));
                end
                if ($urandom_range(0, 1) == 1) begin
                    ev.mkey = 8'(MOD_FIRST + $urandom_range(0, 7));
                end else begin
                    ev.mkey = 8'($urandom_range(0, 255));
                end
                ev.prs     = ($urandom_range(0, 99) < 55);
                ev.typed_n = -1;
                ev.mods    = 8'h00;
                ev.slots   = '0;
                send_event(ev);
                if (ev.kind != KIND_NONE) begin
                    count++;
                end
            end
        end

        // Drain, then leave room for any surplus report to show up.
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (err_count == 0) begin
            $display("PASS hid_keyboard_report_builder_top");
        end else begin
            $display("FAIL hid_keyboard_report_builder_top");
        end
        $finish;
    end

endmodule
